>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the line rasterizer checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define DLR_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition never holds outside reset.
`define DLR_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> src/dlr_pkg.sv
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared constants, codes and types of the line rasterizer.
// ----------------------------------------------------------------------------
package dlr_pkg;

	// Canvas and fixed point format
	localparam int CANVAS_WIDTH  = 800;
	localparam int CANVAS_HEIGHT = 600;
	localparam int FRACTION_BITS = 16;

	// Field widths
	localparam int COORD_W = 12;
	localparam int MAG_W   = 12;
	localparam int COLOR_W = 8;
	localparam int CFG_IDX_W = 2;

	// Derived datapath widths
	localparam int STEPS_W   = MAG_W + 1;
	localparam int POS_W     = COORD_W + 1 + FRACTION_BITS;
	localparam int QUO_W     = FRACTION_BITS + 1;
	localparam int STEP_W    = QUO_W + 1;
	localparam int NUM_W     = MAG_W + FRACTION_BITS + 1;
	localparam int PIX_W     = POS_W + 1 - FRACTION_BITS;
	localparam int DIV_CNT_W = $clog2(QUO_W + 1);

	// Command queue
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Function codes
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_STEP = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RED   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE  = 2'd2;

	// Classified command word held in the queue
	typedef struct packed {
		logic                      func;
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic                      neg_x;
		logic                      neg_y;
		logic [MAG_W-1:0]          mag_x;
		logic [MAG_W-1:0]          mag_y;
		logic [MAG_W-1:0]          steps;
	} cmd_t;

	// Divider request and response
	typedef struct packed {
		logic             start;
		logic [MAG_W-1:0] divisor;
		logic [MAG_W-1:0] mag_x;
		logic [MAG_W-1:0] mag_y;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo_x;
		logic [QUO_W-1:0] quo_y;
	} div_rsp_t;

	// Current drawing color
	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} color_t;

endpackage

>>> src/dlr_front.sv
// ----------------------------------------------------------------------------
// dlr_front
// Input side: accepts words, works out deltas and step count, and queues them.
// ----------------------------------------------------------------------------
module dlr_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              func,
	input  logic signed [dlr_pkg::COORD_W-1:0] start_x,
	input  logic signed [dlr_pkg::COORD_W-1:0] start_y,
	input  logic signed [dlr_pkg::COORD_W-1:0] end_x,
	input  logic signed [dlr_pkg::COORD_W-1:0] end_y,
	output logic                              cmd_valid,
	output dlr_pkg::cmd_t                     cmd,
	input  logic                              cmd_pop
);

	logic signed [dlr_pkg::COORD_W:0] dx;
	logic signed [dlr_pkg::COORD_W:0] dy;
	logic [dlr_pkg::COORD_W:0]        abs_x;
	logic [dlr_pkg::COORD_W:0]        abs_y;
	dlr_pkg::cmd_t                    cmd_in;
	logic                             push;

	dlr_pkg::cmd_t                      queue_q [dlr_pkg::QUEUE_DEPTH];
	logic [dlr_pkg::QUEUE_PTR_W-1:0]    wr_ptr_q;
	logic [dlr_pkg::QUEUE_PTR_W-1:0]    rd_ptr_q;
	logic [dlr_pkg::QUEUE_CNT_W-1:0]    count_q;

	// Classify: signed deltas, magnitudes and the longer axis
	always_comb begin
		dx    = (dlr_pkg::COORD_W+1)'(end_x) - (dlr_pkg::COORD_W+1)'(start_x);
		dy    = (dlr_pkg::COORD_W+1)'(end_y) - (dlr_pkg::COORD_W+1)'(start_y);
		abs_x = dx[dlr_pkg::COORD_W] ? -dx : dx;
		abs_y = dy[dlr_pkg::COORD_W] ? -dy : dy;
		cmd_in.func    = func;
		cmd_in.start_x = start_x;
		cmd_in.start_y = start_y;
		cmd_in.neg_x   = dx[dlr_pkg::COORD_W];
		cmd_in.neg_y   = dy[dlr_pkg::COORD_W];
		cmd_in.mag_x   = abs_x[dlr_pkg::MAG_W-1:0];
		cmd_in.mag_y   = abs_y[dlr_pkg::MAG_W-1:0];
		cmd_in.steps   = (abs_x > abs_y) ? abs_x[dlr_pkg::MAG_W-1:0]
		                                 : abs_y[dlr_pkg::MAG_W-1:0];
	end

	assign in_stall  = (count_q == dlr_pkg::QUEUE_CNT_W'(dlr_pkg::QUEUE_DEPTH));
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (count_q != '0);
	assign cmd       = queue_q[rd_ptr_q];

	// Store pushed words
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd_in;
		end
	end

	// Advance pointers and the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == dlr_pkg::QUEUE_PTR_W'(dlr_pkg::QUEUE_DEPTH - 1))
				            ? '0 : wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= (rd_ptr_q == dlr_pkg::QUEUE_PTR_W'(dlr_pkg::QUEUE_DEPTH - 1))
				            ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && cmd_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> src/dlr_divider.sv
// ----------------------------------------------------------------------------
// dlr_divider
// Two-lane restoring divider for the per-axis increments, one bit a cycle.
// Computes round(mag * 2^FRACTION_BITS / steps) for both axes.
// ----------------------------------------------------------------------------
module dlr_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  dlr_pkg::div_req_t req,
	output dlr_pkg::div_rsp_t rsp
);

	localparam logic [dlr_pkg::DIV_CNT_W-1:0] LAST_ITER =
		dlr_pkg::DIV_CNT_W'(dlr_pkg::QUO_W - 1);

	logic                              busy_q;
	logic                              done_q;
	logic [dlr_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [dlr_pkg::MAG_W-1:0]         div_q;
	logic [dlr_pkg::MAG_W-1:0]         rem_x_q;
	logic [dlr_pkg::MAG_W-1:0]         rem_y_q;
	logic [dlr_pkg::QUO_W-1:0]         sh_x_q;
	logic [dlr_pkg::QUO_W-1:0]         sh_y_q;
	logic [dlr_pkg::NUM_W-1:0]         num_x;
	logic [dlr_pkg::NUM_W-1:0]         num_y;
	logic [dlr_pkg::MAG_W:0]           iter_x;
	logic [dlr_pkg::MAG_W:0]           iter_y;

	// One restoring step: returns {quotient bit, next remainder}
	function automatic logic [dlr_pkg::MAG_W:0] div_iter(
		input logic [dlr_pkg::MAG_W-1:0] rem,
		input logic                      nbit,
		input logic [dlr_pkg::MAG_W-1:0] dvs
	);
		logic [dlr_pkg::MAG_W+1:0] diff;
		logic [dlr_pkg::MAG_W:0]   shifted;
		shifted = {rem, nbit};
		diff    = {1'b0, shifted} - {2'b00, dvs};
		if (diff[dlr_pkg::MAG_W+1]) begin
			div_iter = {1'b0, shifted[dlr_pkg::MAG_W-1:0]};
		end else begin
			div_iter = {1'b1, diff[dlr_pkg::MAG_W-1:0]};
		end
	endfunction

	// Numerators with the rounding term folded in
	assign num_x = {1'b0, req.mag_x, {dlr_pkg::FRACTION_BITS{1'b0}}}
	             + dlr_pkg::NUM_W'(req.divisor[dlr_pkg::MAG_W-1:1]);
	assign num_y = {1'b0, req.mag_y, {dlr_pkg::FRACTION_BITS{1'b0}}}
	             + dlr_pkg::NUM_W'(req.divisor[dlr_pkg::MAG_W-1:1]);

	assign iter_x = div_iter(rem_x_q, sh_x_q[dlr_pkg::QUO_W-1], div_q);
	assign iter_y = div_iter(rem_y_q, sh_y_q[dlr_pkg::QUO_W-1], div_q);

	// Datapath: load numerators, then shift quotient bits in
	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q   <= req.divisor;
			rem_x_q <= num_x[dlr_pkg::NUM_W-1:dlr_pkg::QUO_W];
			rem_y_q <= num_y[dlr_pkg::NUM_W-1:dlr_pkg::QUO_W];
			sh_x_q  <= num_x[dlr_pkg::QUO_W-1:0];
			sh_y_q  <= num_y[dlr_pkg::QUO_W-1:0];
		end else if (busy_q) begin
			rem_x_q <= iter_x[dlr_pkg::MAG_W-1:0];
			rem_y_q <= iter_y[dlr_pkg::MAG_W-1:0];
			sh_x_q  <= {sh_x_q[dlr_pkg::QUO_W-2:0], iter_x[dlr_pkg::MAG_W]};
			sh_y_q  <= {sh_y_q[dlr_pkg::QUO_W-2:0], iter_y[dlr_pkg::MAG_W]};
		end
	end

	// Control: count iterations and flag completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST_ITER) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.quo_x = sh_x_q;
	assign rsp.quo_y = sh_y_q;

endmodule

>>> src/dlr_back.sv
// ----------------------------------------------------------------------------
// dlr_back
// Execution side: takes queued words, sets up lines, walks the accumulators
// and holds each pixel in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dlr_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	input  dlr_pkg::cmd_t                      cmd,
	output logic                               cmd_pop,
	output dlr_pkg::div_req_t                  div_req,
	input  dlr_pkg::div_rsp_t                  div_rsp,
	input  dlr_pkg::color_t                    color,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [dlr_pkg::COORD_W-1:0] pixel_x,
	output logic signed [dlr_pkg::COORD_W-1:0] pixel_y,
	output logic                               pixel_visible,
	output logic [dlr_pkg::COLOR_W-1:0]        pixel_red,
	output logic [dlr_pkg::COLOR_W-1:0]        pixel_green,
	output logic [dlr_pkg::COLOR_W-1:0]        pixel_blue,
	output logic                               last_pixel
);

	localparam logic signed [dlr_pkg::POS_W:0] HALF =
		(dlr_pkg::POS_W+1)'(1) <<< (dlr_pkg::FRACTION_BITS - 1);
	localparam logic [dlr_pkg::PIX_W-2:0] CANVAS_X = (dlr_pkg::PIX_W-1)'(dlr_pkg::CANVAS_WIDTH);
	localparam logic [dlr_pkg::PIX_W-2:0] CANVAS_Y = (dlr_pkg::PIX_W-1)'(dlr_pkg::CANVAS_HEIGHT);

	logic                               active_q;
	logic                               wait_q;
	logic                               neg_x_q;
	logic                               neg_y_q;
	logic signed [dlr_pkg::POS_W-1:0]   xpos_q;
	logic signed [dlr_pkg::POS_W-1:0]   ypos_q;
	logic signed [dlr_pkg::STEP_W-1:0]  xstep_q;
	logic signed [dlr_pkg::STEP_W-1:0]  ystep_q;
	logic [dlr_pkg::STEPS_W-1:0]        remain_q;
	logic                               out_valid_q;

	logic                               out_free;
	logic                               is_load;
	logic                               emit;
	logic                               last;
	logic signed [dlr_pkg::PIX_W-1:0]   rx;
	logic signed [dlr_pkg::PIX_W-1:0]   ry;
	logic signed [dlr_pkg::STEP_W-1:0]  qx;
	logic signed [dlr_pkg::STEP_W-1:0]  qy;

	// Round a fixed point position to the nearest integer, ties away from zero
	function automatic logic signed [dlr_pkg::PIX_W-1:0] round_pos(
		input logic signed [dlr_pkg::POS_W-1:0] pos
	);
		logic signed [dlr_pkg::POS_W:0] sum;
		sum = (dlr_pkg::POS_W+1)'(pos) + (pos[dlr_pkg::POS_W-1] ? HALF - 1'b1 : HALF);
		round_pos = dlr_pkg::PIX_W'(sum >>> dlr_pkg::FRACTION_BITS);
	endfunction

	// Pop decision: held while dividing; loads and stray steps go, line steps need room
	assign out_free = !out_valid_q || !out_stall;
	assign is_load  = (cmd.func == dlr_pkg::FUNC_LOAD);
	assign cmd_pop  = cmd_valid && !wait_q && (is_load || !active_q || out_free);
	assign emit     = cmd_pop && !is_load && active_q;
	assign last     = (remain_q <= dlr_pkg::STEPS_W'(1));

	assign rx = round_pos(xpos_q);
	assign ry = round_pos(ypos_q);

	// Start the divider for any line longer than one pixel
	assign div_req.start   = cmd_pop && is_load && (cmd.steps != '0);
	assign div_req.divisor = cmd.steps;
	assign div_req.mag_x   = cmd.mag_x;
	assign div_req.mag_y   = cmd.mag_y;

	assign qx = {1'b0, div_rsp.quo_x};
	assign qy = {1'b0, div_rsp.quo_y};

	// Line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			wait_q   <= 1'b0;
			neg_x_q  <= 1'b0;
			neg_y_q  <= 1'b0;
			xpos_q   <= '0;
			ypos_q   <= '0;
			xstep_q  <= '0;
			ystep_q  <= '0;
			remain_q <= '0;
		end else begin
			if (div_rsp.done) begin
				xstep_q <= neg_x_q ? -qx : qx;
				ystep_q <= neg_y_q ? -qy : qy;
				wait_q  <= 1'b0;
			end
			if (cmd_pop && is_load) begin
				active_q <= 1'b1;
				wait_q   <= (cmd.steps != '0);
				neg_x_q  <= cmd.neg_x;
				neg_y_q  <= cmd.neg_y;
				xpos_q   <= {cmd.start_x[dlr_pkg::COORD_W-1], cmd.start_x,
				             {dlr_pkg::FRACTION_BITS{1'b0}}};
				ypos_q   <= {cmd.start_y[dlr_pkg::COORD_W-1], cmd.start_y,
				             {dlr_pkg::FRACTION_BITS{1'b0}}};
				xstep_q  <= '0;
				ystep_q  <= '0;
				remain_q <= dlr_pkg::STEPS_W'(cmd.steps) + dlr_pkg::STEPS_W'(1);
			end else if (emit) begin
				xpos_q <= xpos_q + dlr_pkg::POS_W'(xstep_q);
				ypos_q <= ypos_q + dlr_pkg::POS_W'(ystep_q);
				if (last) begin
					active_q <= 1'b0;
					remain_q <= '0;
				end else begin
					remain_q <= remain_q - 1'b1;
				end
			end
		end
	end

	// Output word valid: set on emit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output word payload
	always_ff @(posedge clk) begin
		if (emit) begin
			pixel_x       <= rx[dlr_pkg::COORD_W-1:0];
			pixel_y       <= ry[dlr_pkg::COORD_W-1:0];
			pixel_visible <= !rx[dlr_pkg::PIX_W-1] && (rx[dlr_pkg::PIX_W-2:0] < CANVAS_X)
			              && !ry[dlr_pkg::PIX_W-1] && (ry[dlr_pkg::PIX_W-2:0] < CANVAS_Y);
			pixel_red     <= color.red;
			pixel_green   <= color.green;
			pixel_blue    <= color.blue;
			last_pixel    <= last;
		end
	end

	assign out_valid = out_valid_q;

	`DLR_ASSERT_NEVER(a_emit_over_held, emit && out_valid_q && out_stall, "pixel overwrote a held word")
	`DLR_ASSERT_IMPLY(a_pop_not_waiting, cmd_pop, !wait_q, "word taken during increment division")
	`DLR_ASSERT_IMPLY(a_idle_no_remain, !active_q, remain_q == '0, "idle line with pixels left")
	`DLR_ASSERT_IMPLY(a_done_when_waiting, div_rsp.done, wait_q && active_q, "unexpected divider result")

endmodule

>>> src/dda_line_rasterizer.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line rasterizer: loads endpoints, then emits one pixel per step word.
//
// Usage:
//   Input channel (in_valid / in_stall): func 0 loads a line from start_x/y to
//   end_x/y; func 1 asks for the next pixel of the active line. A step word
//   with no active line is dropped without output.
//   Output channel (out_valid / out_stall): one pixel word per step word on an
//   active line, with coordinate, canvas visibility, color and last flag.
//   Config channel (cfg_valid / cfg_ready): writes the red, green and blue
//   registers; cfg_ready is always high. Write only while the block is idle.
//   A step word is registered into the output register when the back end takes
//   it from the queue; steps sustain one pixel per cycle while the output is
//   not stalled. A load holds the back end until the one-bit-per-cycle
//   increment divider returns; a single-pixel line skips the divider.
//   A two-word queue lets input be accepted while the back end divides.
//   Reset clears the line state and queue and sets the color to red.
//   When out_stall is high a held pixel word stays and the back end stops taking
//   step words for the active line; input stalls once the queue is full.
// ----------------------------------------------------------------------------
module dda_line_rasterizer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                func,
	input  logic signed [dlr_pkg::COORD_W-1:0]  start_x,
	input  logic signed [dlr_pkg::COORD_W-1:0]  start_y,
	input  logic signed [dlr_pkg::COORD_W-1:0]  end_x,
	input  logic signed [dlr_pkg::COORD_W-1:0]  end_y,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [dlr_pkg::COORD_W-1:0]  pixel_x,
	output logic signed [dlr_pkg::COORD_W-1:0]  pixel_y,
	output logic                                pixel_visible,
	output logic [dlr_pkg::COLOR_W-1:0]         pixel_red,
	output logic [dlr_pkg::COLOR_W-1:0]         pixel_green,
	output logic [dlr_pkg::COLOR_W-1:0]         pixel_blue,
	output logic                                last_pixel,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dlr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dlr_pkg::COLOR_W-1:0]         cfg_data
);

	dlr_pkg::color_t   color_q;
	dlr_pkg::cmd_t     cmd;
	logic              cmd_valid;
	logic              cmd_pop;
	dlr_pkg::div_req_t div_req;
	dlr_pkg::div_rsp_t div_rsp;

	assign cfg_ready = 1'b1;

	// Color registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q.red   <= '1;
			color_q.green <= '0;
			color_q.blue  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				dlr_pkg::REG_RED:   color_q.red   <= cfg_data;
				dlr_pkg::REG_GREEN: color_q.green <= cfg_data;
				dlr_pkg::REG_BLUE:  color_q.blue  <= cfg_data;
				default: ;
			endcase
		end
	end

	dlr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.start_x   (start_x),
		.start_y   (start_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	dlr_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	dlr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_pop       (cmd_pop),
		.div_req       (div_req),
		.div_rsp       (div_rsp),
		.color         (color_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.pixel_visible (pixel_visible),
		.pixel_red     (pixel_red),
		.pixel_green   (pixel_green),
		.pixel_blue    (pixel_blue),
		.last_pixel    (last_pixel)
	);

endmodule

>>> dv/tb_dda_line_rasterizer.sv
// ----------------------------------------------------------------------------
// tb_dda_line_rasterizer
// Self-checking bench for the DDA line rasterizer. A line predictor in the
// bench tracks the fixed-point accumulators and the pen color. Each accepted
// step word that hits an active line queues the expected pixel, and every
// pixel word leaving the block is checked field by field against the oldest
// pixel in that queue. Directed cases cover the endpoint extremes, rounding
// ties, zero-length lines, stray steps, line replacement, a color change in
// the middle of a line and one long output hold-off. A long random run
// follows, with idle gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
module tb_dda_line_rasterizer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int SETTLE_CYCLES = 64;
	localparam int RANDOM_WORDS  = 800;
	localparam int MAX_PRINTS    = 100;
	// index past the last color register, written to check that it is ignored
	localparam logic [dlr_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic signed [dlr_pkg::COORD_W-1:0] x;
		logic signed [dlr_pkg::COORD_W-1:0] y;
		logic                               visible;
		dlr_pkg::color_t                    color;
		logic                               last;
	} pixel_t;

	logic                                 clk;
	logic                                 arst_n    = 1'b0;
	logic                                 in_valid  = 1'b0;
	logic                                 in_stall;
	logic                                 func      = dlr_pkg::FUNC_STEP;
	logic signed [dlr_pkg::COORD_W-1:0]   start_x   = '0;
	logic signed [dlr_pkg::COORD_W-1:0]   start_y   = '0;
	logic signed [dlr_pkg::COORD_W-1:0]   end_x     = '0;
	logic signed [dlr_pkg::COORD_W-1:0]   end_y     = '0;
	logic                                 out_valid;
	logic                                 out_stall = 1'b0;
	logic signed [dlr_pkg::COORD_W-1:0]   pixel_x;
	logic signed [dlr_pkg::COORD_W-1:0]   pixel_y;
	logic                                 pixel_visible;
	logic [dlr_pkg::COLOR_W-1:0]          pixel_red;
	logic [dlr_pkg::COLOR_W-1:0]          pixel_green;
	logic [dlr_pkg::COLOR_W-1:0]          pixel_blue;
	logic                                 last_pixel;
	logic                                 cfg_valid = 1'b0;
	logic                                 cfg_ready;
	logic [dlr_pkg::CFG_IDX_W-1:0]        cfg_index = dlr_pkg::REG_RED;
	logic [dlr_pkg::COLOR_W-1:0]          cfg_data  = '0;

	// line predictor state
	logic                                 line_live   = 1'b0;
	logic signed [dlr_pkg::POS_W-1:0]     x_acc       = '0;
	logic signed [dlr_pkg::POS_W-1:0]     y_acc       = '0;
	logic signed [dlr_pkg::STEP_W-1:0]    x_inc       = '0;
	logic signed [dlr_pkg::STEP_W-1:0]    y_inc       = '0;
	logic [dlr_pkg::STEPS_W-1:0]          pixels_left = '0;
	dlr_pkg::color_t                      pen         = '{red: 8'hFF, green: '0, blue: '0};

	pixel_t pixels_due[$];

	int cycle_count    = 0;
	int mismatches     = 0;
	int pixels_checked = 0;
	int words_counted  = 0;
	int in_idle_pct    = 33;
	int out_stall_pct  = 33;
	int hold_req       = 0;
	int hold_left      = 0;

	dda_line_rasterizer i_dut (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pixels pending",
				cycle_count, pixels_due.size());
			$display("tb_dda_line_rasterizer: FAIL");
			$finish;
		end
	end

	// drive output stall: random, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (hold_req > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_req - 1;
			hold_req = 0;
		end else begin
			out_stall <= ($urandom_range(99) < out_stall_pct);
		end
	end

	function automatic longint increment_of(longint d, longint span);
		longint mag;
		longint q;
		if (span <= 0)
			return 0;
		mag = (d < 0) ? -d : d;
		q = ((mag << dlr_pkg::FRACTION_BITS) + span / 2) / span;
		return (d < 0) ? -q : q;
	endfunction

	function automatic longint round_away(longint p);
		longint mag;
		longint r;
		mag = (p < 0) ? -p : p;
		r = (mag + (longint'(1) << (dlr_pkg::FRACTION_BITS - 1))) >>> dlr_pkg::FRACTION_BITS;
		return (p < 0) ? -r : r;
	endfunction

	// advance the predictor by one word; return 1 if it counts as real work
	function automatic bit rasterize_word(logic f, logic signed [dlr_pkg::COORD_W-1:0] sx,
			logic signed [dlr_pkg::COORD_W-1:0] sy, logic signed [dlr_pkg::COORD_W-1:0] ex,
			logic signed [dlr_pkg::COORD_W-1:0] ey);
		longint dx, dy, ax, ay, span, px, py;
		pixel_t pix;
		if (f == dlr_pkg::FUNC_LOAD) begin
			dx = longint'(ex) - longint'(sx);
			dy = longint'(ey) - longint'(sy);
			ax = (dx < 0) ? -dx : dx;
			ay = (dy < 0) ? -dy : dy;
			span = (ax > ay) ? ax : ay;
			x_inc = dlr_pkg::STEP_W'(increment_of(dx, span));
			y_inc = dlr_pkg::STEP_W'(increment_of(dy, span));
			x_acc = dlr_pkg::POS_W'(longint'(sx) * (longint'(1) << dlr_pkg::FRACTION_BITS));
			y_acc = dlr_pkg::POS_W'(longint'(sy) * (longint'(1) << dlr_pkg::FRACTION_BITS));
			pixels_left = dlr_pkg::STEPS_W'(span + 1);
			line_live = 1'b1;
			return 1'b1;
		end
		// drop steps with no active line
		if (!line_live)
			return 1'b0;
		px = round_away(longint'(x_acc));
		py = round_away(longint'(y_acc));
		pix.x = dlr_pkg::COORD_W'(px);
		pix.y = dlr_pkg::COORD_W'(py);
		pix.visible = (px >= 0) && (px < dlr_pkg::CANVAS_WIDTH)
		           && (py >= 0) && (py < dlr_pkg::CANVAS_HEIGHT);
		pix.color = pen;
		pix.last = (pixels_left <= dlr_pkg::STEPS_W'(1));
		pixels_due.push_back(pix);
		x_acc = x_acc + x_inc;
		y_acc = y_acc + y_inc;
		if (pix.last) begin
			pixels_left = '0;
			line_live = 1'b0;
		end else begin
			pixels_left = pixels_left - 1'b1;
		end
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_PRINTS)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input longint got, input longint want);
		if (got != want)
			report_mismatch($sformatf("pixel %0d %s got %0d expected %0d",
				pixels_checked, name, got, want));
	endtask

	// check each pixel word against the oldest pending pixel
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pixels_due.size() == 0) begin
				report_mismatch($sformatf("pixel word (%0d,%0d) with no pixel pending",
					pixel_x, pixel_y));
			end else begin
				want = pixels_due.pop_front();
				check_field("pixel_x", pixel_x, want.x);
				check_field("pixel_y", pixel_y, want.y);
				check_field("pixel_visible", pixel_visible, want.visible);
				check_field("pixel_red", pixel_red, want.color.red);
				check_field("pixel_green", pixel_green, want.color.green);
				check_field("pixel_blue", pixel_blue, want.color.blue);
				check_field("last_pixel", last_pixel, want.last);
			end
			pixels_checked++;
		end
	end

	function automatic logic signed [dlr_pkg::COORD_W-1:0] any_coord();
		return dlr_pkg::COORD_W'($urandom_range(4095));
	endfunction

	function automatic logic signed [dlr_pkg::COORD_W-1:0] clamp_coord(int v);
		if (v > 2047)
			return dlr_pkg::COORD_W'(2047);
		if (v < -2048)
			return dlr_pkg::COORD_W'(-2048);
		return dlr_pkg::COORD_W'(v);
	endfunction

	// offer one word and hold it until accepted; valid stays high on return
	task automatic send_word(input logic f, input logic signed [dlr_pkg::COORD_W-1:0] sx,
			input logic signed [dlr_pkg::COORD_W-1:0] sy,
			input logic signed [dlr_pkg::COORD_W-1:0] ex,
			input logic signed [dlr_pkg::COORD_W-1:0] ey);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		start_x  <= sx;
		start_y  <= sy;
		end_x    <= ex;
		end_y    <= ey;
		do @(posedge clk); while (in_stall);
		if (rasterize_word(f, sx, sy, ex, ey))
			words_counted++;
		@(negedge clk);
	endtask

	task automatic send_steps(input int count);
		repeat (count)
			send_word(dlr_pkg::FUNC_STEP, any_coord(), any_coord(), any_coord(), any_coord());
	endtask

	task automatic write_reg(input logic [dlr_pkg::CFG_IDX_W-1:0] idx,
			input logic [dlr_pkg::COLOR_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		unique case (idx)
			dlr_pkg::REG_RED:   pen.red = val;
			dlr_pkg::REG_GREEN: pen.green = val;
			dlr_pkg::REG_BLUE:  pen.blue = val;
			default:   ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// drop valid, wait for all pixels, then let a pending divide finish
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pixels_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic test_idle_step();
		send_steps(1);
	endtask

	task automatic test_zero_length();
		send_word(dlr_pkg::FUNC_LOAD, 12'sd5, 12'sd7, 12'sd5, 12'sd7);
		send_steps(2);
	endtask

	task automatic test_rounding_ties();
		// half-pixel positions round away from zero on both sides
		send_word(dlr_pkg::FUNC_LOAD, 12'sd0, 12'sd0, 12'sd1, 12'sd2);
		send_steps(3);
		send_word(dlr_pkg::FUNC_LOAD, 12'sd0, 12'sd0, -12'sd1, -12'sd2);
		send_steps(3);
	endtask

	task automatic test_extremes();
		send_word(dlr_pkg::FUNC_LOAD, -12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047);
		send_steps(2);
		// replace the active line mid-way
		send_word(dlr_pkg::FUNC_LOAD, 12'sd2047, -12'sd2048, -12'sd2048, 12'sd2047);
		send_steps(2);
		// canvas corner: inside, then just outside
		send_word(dlr_pkg::FUNC_LOAD, 12'sd799, 12'sd599, 12'sd800, 12'sd600);
		send_steps(2);
	endtask

	task automatic test_color_mid_line();
		send_word(dlr_pkg::FUNC_LOAD, 12'sd10, 12'sd10, 12'sd13, 12'sd12);
		send_steps(2);
		settle();
		write_reg(dlr_pkg::REG_GREEN, 8'd128);
		send_steps(2);
		settle();
	endtask

	task automatic test_backpressure();
		hold_req = 400;
		in_idle_pct = 0;
		send_word(dlr_pkg::FUNC_LOAD, 12'sd0, 12'sd0, 12'sd120, 12'sd50);
		send_steps(121);
		in_idle_pct = 33;
		settle();
	endtask

	task automatic random_line();
		logic signed [dlr_pkg::COORD_W-1:0] sx, sy, ex, ey;
		int reach, span, ax, ay, n_steps, pick;
		pick = $urandom_range(99);
		if (pick < 5) begin
			sx = any_coord();
			sy = any_coord();
			ex = any_coord();
			ey = any_coord();
		end else begin
			if ($urandom_range(1)) begin
				sx = dlr_pkg::COORD_W'(int'($urandom_range(840)) - 20);
				sy = dlr_pkg::COORD_W'(int'($urandom_range(640)) - 20);
			end else begin
				sx = any_coord();
				sy = any_coord();
			end
			reach = (pick < 20) ? 200 : 12;
			ex = clamp_coord(int'(sx) + int'($urandom_range(2 * reach)) - reach);
			ey = clamp_coord(int'(sy) + int'($urandom_range(2 * reach)) - reach);
		end
		ax = int'(ex) - int'(sx);
		ay = int'(ey) - int'(sy);
		ax = (ax < 0) ? -ax : ax;
		ay = (ay < 0) ? -ay : ay;
		span = ((ax > ay) ? ax : ay) + 1;
		// mostly whole lines; some cut short, some with stray steps after
		pick = $urandom_range(99);
		if (span > 300)
			n_steps = $urandom_range(40, 1);
		else if (pick < 75)
			n_steps = span;
		else if (pick < 88)
			n_steps = $urandom_range(span - 1, 0);
		else
			n_steps = span + $urandom_range(3, 1);
		send_word(dlr_pkg::FUNC_LOAD, sx, sy, ex, ey);
		send_steps(n_steps);
	endtask

	task automatic test_random_lines();
		int goal;
		for (int phase = 0; phase < 4; phase++) begin
			settle();
			unique case (phase)
				0: begin
					write_reg(dlr_pkg::REG_RED, 8'd0);
					write_reg(dlr_pkg::REG_GREEN, 8'd0);
					write_reg(dlr_pkg::REG_BLUE, 8'd0);
					write_reg(REG_SPARE, 8'($urandom_range(255)));
				end
				1: begin
					write_reg(dlr_pkg::REG_RED, 8'd255);
					write_reg(dlr_pkg::REG_GREEN, 8'd255);
					write_reg(dlr_pkg::REG_BLUE, 8'd255);
				end
				default: begin
					write_reg(dlr_pkg::REG_RED, 8'($urandom_range(255)));
					write_reg(dlr_pkg::REG_GREEN, 8'($urandom_range(255)));
					write_reg(dlr_pkg::REG_BLUE, 8'($urandom_range(255)));
					write_reg(REG_SPARE, 8'($urandom_range(255)));
				end
			endcase
			// one phase runs with no idling on either side
			in_idle_pct = (phase == 2) ? 0 : 33;
			out_stall_pct = (phase == 2) ? 0 : 33;
			goal = words_counted + RANDOM_WORDS / 4;
			while (words_counted < goal)
				random_line();
		end
		in_idle_pct = 33;
		out_stall_pct = 33;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_idle_step();
		test_zero_length();
		test_rounding_ties();
		test_extremes();
		settle();
		test_color_mid_line();
		test_backpressure();
		test_random_lines();
		settle();

		if (pixels_due.size() != 0)
			report_mismatch($sformatf("%0d pixels never arrived", pixels_due.size()));
		if (mismatches == 0)
			$display("tb_dda_line_rasterizer: PASS");
		else
			$display("tb_dda_line_rasterizer: FAIL");
		$finish;
	end

endmodule

>>> sim.f
+incdir+src
src/dlr_pkg.sv
src/dlr_front.sv
src/dlr_divider.sv
src/dlr_back.sv
src/dda_line_rasterizer.sv
dv/tb_dda_line_rasterizer.sv
